>>> rtl/qrv_pkg.sv
// Package: shared constants, the arctangent step table and the job record for the converter.
`timescale 1ns / 1ps
`default_nettype none
package qrv_pkg;

    localparam int LANES        = 3;
    localparam int SQRT_STEPS   = 31;
    localparam int CORDIC_STEPS = 31;
    localparam int GUARD_BITS   = 16;
    localparam int CW           = 50;
    localparam int ZW           = 35;
    localparam int DIV_STEPS    = 32;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [61:0] ONE_SQ_Q60  = 62'h1000_0000_0000_0000;
    localparam logic [32:0] PI_Q30      = 33'd3373259426;
    localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
    localparam logic [31:0] ROT_MAX     = 32'd1686629713;
    localparam logic [15:0] THRESH_RST  = 16'd268;

    typedef struct packed {
        logic [32:0]            theta;
        logic [30:0]            s;
        logic [LANES-1:0][31:0] comp;
        logic                   small_ang;
        logic                   degen;
    } t_job;

    // atan(2^-i) in units of 2^-30 rad; exact power of two from step 11 on
    function automatic logic [ZW-1:0] atan_step(input int idx);
        logic [ZW-1:0] v;
        case (idx)
            0:       v = ZW'(843314857);
            1:       v = ZW'(497837829);
            2:       v = ZW'(263043837);
            3:       v = ZW'(133525159);
            4:       v = ZW'(67021687);
            5:       v = ZW'(33543516);
            6:       v = ZW'(16775851);
            7:       v = ZW'(8388437);
            8:       v = ZW'(4194283);
            9:       v = ZW'(2097149);
            10:      v = ZW'(1048576);
            default: v = ZW'(64'd1 << (30 - idx));
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/qrv_front.sv
// Front end: clamp, square root of the sine term, CORDIC angle and classification.
`timescale 1ns / 1ps
`default_nettype none
module qrv_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [31:0]   i_w,
    input  wire logic [31:0]   i_x,
    input  wire logic [31:0]   i_y,
    input  wire logic [31:0]   i_z,
    input  wire logic [15:0]   i_thresh,
    output logic               o_valid,
    output qrv_pkg::t_job      o_job
);
    import qrv_pkg::*;

    // clamp stage
    logic [31:0]            w_abs;
    logic [30:0]            n_aw;
    logic                   r_v0, r_v1, r_v2;
    logic [30:0]            r_aw0, r_aw1, r_aw2;
    logic                   r_neg0, r_neg1, r_neg2;
    logic [LANES-1:0][31:0] r_c0, r_c1, r_c2;
    logic [61:0]            r_sq1, r_rad2;

    assign w_abs = i_w[31] ? (32'd0 - i_w) : i_w;
    assign n_aw  = (w_abs > {1'b0, ONE_Q30}) ? ONE_Q30 : w_abs[30:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_aw0  <= n_aw;
        r_neg0 <= i_w[31];
        r_c0   <= {i_z, i_y, i_x};
        r_sq1  <= r_aw0 * r_aw0;
        r_aw1  <= r_aw0;
        r_neg1 <= r_neg0;
        r_c1   <= r_c0;
        r_rad2 <= ONE_SQ_Q60 - r_sq1;
        r_aw2  <= r_aw1;
        r_neg2 <= r_neg1;
        r_c2   <= r_c1;
    end

    // square root, one result bit per stage
    logic                   r_sv   [0:SQRT_STEPS];
    logic [30:0]            r_root [0:SQRT_STEPS];
    logic [32:0]            r_rem  [0:SQRT_STEPS];
    logic [61:0]            r_rad  [0:SQRT_STEPS];
    logic [30:0]            r_saw  [0:SQRT_STEPS];
    logic                   r_sneg [0:SQRT_STEPS];
    logic [LANES-1:0][31:0] r_sc   [0:SQRT_STEPS];

    assign r_sv[0]   = r_v2;
    assign r_root[0] = '0;
    assign r_rem[0]  = '0;
    assign r_rad[0]  = r_rad2;
    assign r_saw[0]  = r_aw2;
    assign r_sneg[0] = r_neg2;
    assign r_sc[0]   = r_c2;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        logic [34:0] t_sh, trial;
        logic        ge;
        assign t_sh  = {r_rem[k], r_rad[k][61-2*k -: 2]};
        assign trial = {2'b00, r_root[k], 2'b01};
        assign ge    = (t_sh >= trial);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else begin
                r_sv[k+1] <= r_sv[k];
            end
        end
        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= ge ? 33'(t_sh - trial) : t_sh[32:0];
            r_root[k+1] <= {r_root[k][29:0], ge};
            r_rad[k+1]  <= r_rad[k];
            r_saw[k+1]  <= r_saw[k];
            r_sneg[k+1] <= r_sneg[k];
            r_sc[k+1]   <= r_sc[k];
        end
    end

    // CORDIC vectoring, one rotation per stage
    logic                   r_cv   [0:CORDIC_STEPS];
    logic signed [CW-1:0]   r_cx   [0:CORDIC_STEPS];
    logic signed [CW-1:0]   r_cy   [0:CORDIC_STEPS];
    logic signed [ZW-1:0]   r_cz   [0:CORDIC_STEPS];
    logic [30:0]            r_cs   [0:CORDIC_STEPS];
    logic                   r_cneg [0:CORDIC_STEPS];
    logic [LANES-1:0][31:0] r_cc   [0:CORDIC_STEPS];

    assign r_cv[0]   = r_sv[SQRT_STEPS];
    assign r_cx[0]   = signed'({{(CW-31-GUARD_BITS){1'b0}}, r_saw[SQRT_STEPS],
                                {GUARD_BITS{1'b0}}});
    assign r_cy[0]   = signed'({{(CW-31-GUARD_BITS){1'b0}}, r_root[SQRT_STEPS],
                                {GUARD_BITS{1'b0}}});
    assign r_cz[0]   = '0;
    assign r_cs[0]   = r_root[SQRT_STEPS];
    assign r_cneg[0] = r_sneg[SQRT_STEPS];
    assign r_cc[0]   = r_sc[SQRT_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [CW-1:0] dx, dy;
        logic signed [ZW-1:0] ang;
        logic                 pos;
        assign dx  = r_cy[i] >>> i;
        assign dy  = r_cx[i] >>> i;
        assign ang = signed'(atan_step(i));
        assign pos = (r_cy[i] > 0);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[i+1] <= 1'b0;
            end else begin
                r_cv[i+1] <= r_cv[i];
            end
        end
        always_ff @(posedge i_clk) begin
            r_cx[i+1]   <= pos ? r_cx[i] + dx : r_cx[i] - dx;
            r_cy[i+1]   <= pos ? r_cy[i] - dy : r_cy[i] + dy;
            r_cz[i+1]   <= pos ? r_cz[i] + ang : r_cz[i] - ang;
            r_cs[i+1]   <= r_cs[i];
            r_cneg[i+1] <= r_cneg[i];
            r_cc[i+1]   <= r_cc[i];
        end
    end

    // classify: clamp the angle, fold to acos, double, test the special cases
    logic signed [ZW-1:0] z_end;
    logic [32:0]          a_cl, acw, n_theta;
    logic                 r_out_v;
    t_job                 r_job;

    assign z_end   = r_cz[CORDIC_STEPS];
    assign a_cl    = z_end[ZW-1] ? 33'd0 :
                     (z_end > signed'({2'b00, HALF_PI_Q30})) ? HALF_PI_Q30 : z_end[32:0];
    assign acw     = r_cneg[CORDIC_STEPS] ? (PI_Q30 - a_cl) : a_cl;
    assign n_theta = {acw[31:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_cv[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_job.theta     <= n_theta;
        r_job.s         <= r_cs[CORDIC_STEPS];
        r_job.comp      <= r_cc[CORDIC_STEPS];
        r_job.small_ang <= (n_theta < {15'd0, i_thresh, 2'b00});
        r_job.degen     <= (r_cs[CORDIC_STEPS] == 31'd0);
    end

    assign o_valid = r_out_v;
    assign o_job   = r_job;

endmodule
`default_nettype wire

>>> rtl/qrv_queue.sv
// Short job queue between the front end and the scaling back end.
`timescale 1ns / 1ps
`default_nettype none
module qrv_queue (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  qrv_pkg::t_job i_job,
    input  wire logic     i_pop,
    output logic          o_valid,
    output logic          o_full,
    output qrv_pkg::t_job o_job
);
    import qrv_pkg::*;

    t_job       r_mem [0:QUEUE_DEPTH-1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_pop, do_push;

    assign do_pop  = i_pop && (r_cnt != 2'd0);
    assign do_push = i_push && ((r_cnt != 2'(QUEUE_DEPTH)) || do_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'(QUEUE_DEPTH));
    assign o_job   = r_mem[r_rp];

endmodule
`default_nettype wire

>>> rtl/qrv_back.sv
// Back end: scale each component by theta/s with a pipelined divider, saturate, sign.
`timescale 1ns / 1ps
`default_nettype none
module qrv_back (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  qrv_pkg::t_job   i_job,
    output logic            o_done,
    output logic [31:0]     o_rot_x,
    output logic [31:0]     o_rot_y,
    output logic [31:0]     o_rot_z,
    output logic            o_degenerate
);
    import qrv_pkg::*;

    // partial products
    logic                   r_v0, r_v1;
    logic [48:0]            r_plo [0:LANES-1];
    logic [48:0]            r_phi [0:LANES-1];
    logic [LANES-1:0]       r_neg0, r_neg1;
    logic [30:0]            r_s0;
    logic                   r_sm0, r_dg0, r_sm1, r_dg1;
    logic [65:0]            r_num [0:LANES-1];
    logic [32:0]            r_den1;
    logic [31:0]            mag [0:LANES-1];

    for (genvar l = 0; l < LANES; l++) begin : g_mag
        assign mag[l] = i_job.comp[l][31] ? (32'd0 - i_job.comp[l]) : i_job.comp[l];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r_plo[l]  <= i_job.theta * mag[l][15:0];
            r_phi[l]  <= i_job.theta * mag[l][31:16];
            r_neg0[l] <= i_job.comp[l][31];
            r_num[l]  <= 66'(r_plo[l]) + {1'b0, r_phi[l], 16'd0} + {34'd0, r_s0, 1'b0};
        end
        r_s0   <= i_job.s;
        r_sm0  <= i_job.small_ang;
        r_dg0  <= i_job.degen;
        r_den1 <= {r_s0, 2'b00};
        r_neg1 <= r_neg0;
        r_sm1  <= r_sm0;
        r_dg1  <= r_dg0;
    end

    // restoring division, one quotient bit per stage
    logic             r_dv   [0:DIV_STEPS];
    logic [32:0]      r_rem  [0:DIV_STEPS][0:LANES-1];
    logic [31:0]      r_low  [0:DIV_STEPS][0:LANES-1];
    logic [31:0]      r_quo  [0:DIV_STEPS][0:LANES-1];
    logic [LANES-1:0] r_ov   [0:DIV_STEPS];
    logic [32:0]      r_den  [0:DIV_STEPS];
    logic [LANES-1:0] r_dneg [0:DIV_STEPS];
    logic             r_dsm  [0:DIV_STEPS];
    logic             r_ddg  [0:DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else begin
            r_dv[0] <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r_ov[0][l]  <= (r_num[l][65:32] >= {1'b0, r_den1});
            r_rem[0][l] <= r_num[l][64:32];
            r_low[0][l] <= r_num[l][31:0];
            r_quo[0][l] <= '0;
        end
        r_den[0]  <= r_den1;
        r_dneg[0] <= r_neg1;
        r_dsm[0]  <= r_sm1;
        r_ddg[0]  <= r_dg1;
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1] <= 1'b0;
            end else begin
                r_dv[j+1] <= r_dv[j];
            end
        end
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [33:0] t;
            logic        ge;
            assign t  = {r_rem[j][l], r_low[j][l][31-j]};
            assign ge = (t >= {1'b0, r_den[j]});
            always_ff @(posedge i_clk) begin
                r_rem[j+1][l] <= ge ? 33'(t - {1'b0, r_den[j]}) : t[32:0];
                r_quo[j+1][l] <= {r_quo[j][l][30:0], ge};
                r_low[j+1][l] <= r_low[j][l];
            end
        end
        always_ff @(posedge i_clk) begin
            r_ov[j+1]   <= r_ov[j];
            r_den[j+1]  <= r_den[j];
            r_dneg[j+1] <= r_dneg[j];
            r_dsm[j+1]  <= r_dsm[j];
            r_ddg[j+1]  <= r_ddg[j];
        end
    end

    // saturate, sign, special cases
    logic [31:0] res [0:LANES-1];
    logic        zero_out;
    logic        r_done, r_degen;
    logic [31:0] r_rot [0:LANES-1];

    assign zero_out = r_dsm[DIV_STEPS] || r_ddg[DIV_STEPS];

    for (genvar l = 0; l < LANES; l++) begin : g_out
        logic [31:0] qm;
        assign qm = (r_ov[DIV_STEPS][l] || (r_quo[DIV_STEPS][l] > ROT_MAX)) ?
                    ROT_MAX : r_quo[DIV_STEPS][l];
        assign res[l] = zero_out ? 32'd0 : (r_dneg[DIV_STEPS][l] ? (32'd0 - qm) : qm);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_dv[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r_rot[l] <= res[l];
        end
        r_degen <= r_ddg[DIV_STEPS] && !r_dsm[DIV_STEPS];
    end

    assign o_done       = r_done;
    assign o_rot_x      = r_rot[0];
    assign o_rot_y      = r_rot[1];
    assign o_rot_z      = r_rot[2];
    assign o_degenerate = r_degen;

endmodule
`default_nettype wire

>>> rtl/quaternion_to_rotation_vector.sv
// Top level: quaternion to rotation vector converter with its threshold register.
`timescale 1ns / 1ps
`default_nettype none
// Quaternion to rotation vector. Give a unit quaternion in signed Q1.30 with a
// one-cycle start pulse while busy is low; the rotation vector theta*axis comes
// back in signed Q3.28 radians as a one-cycle o_done strobe. Items may be
// started in every cycle: the whole path is a pipeline (31 square-root stages,
// 31 CORDIC stages, 32 divider stages per component), so the sustained rate is
// one item per clock. The receiver cannot stall; results must be taken in the
// o_done cycle. Rotations below 4*threshold (units of 2^-30 rad) give a zero
// vector; w = -1 gives zero and o_degenerate. Write i_cfg_wdata with i_cfg_we
// only while no item is in flight.
module quaternion_to_rotation_vector (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_quat_w,
    input  wire logic [31:0] i_quat_x,
    input  wire logic [31:0] i_quat_y,
    input  wire logic [31:0] i_quat_z,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    output logic             o_done,
    output logic [31:0]      o_rot_x,
    output logic [31:0]      o_rot_y,
    output logic [31:0]      o_rot_z,
    output logic             o_degenerate
);
    import qrv_pkg::*;

    logic [15:0] r_thresh;
    logic        fe_valid, q_valid, q_full;
    t_job        fe_job, q_job;

    // hold the small-angle threshold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RST;
        end else if (i_cfg_we) begin
            r_thresh <= i_cfg_wdata;
        end
    end

    // the back end drains one job per cycle, so the queue never fills and busy stays low
    assign busy = q_full;

    qrv_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start && !busy),
        .i_w      (i_quat_w),
        .i_x      (i_quat_x),
        .i_y      (i_quat_y),
        .i_z      (i_quat_z),
        .i_thresh (r_thresh),
        .o_valid  (fe_valid),
        .o_job    (fe_job)
    );

    qrv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_valid),
        .i_job   (fe_job),
        .i_pop   (1'b1),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_job   (q_job)
    );

    qrv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_job        (q_job),
        .o_done       (o_done),
        .o_rot_x      (o_rot_x),
        .o_rot_y      (o_rot_y),
        .o_rot_z      (o_rot_z),
        .o_degenerate (o_degenerate)
    );

endmodule
`default_nettype wire

>>> rtl/qrv_checker.sv
// Port-level checks for the converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module qrv_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        busy,
    input wire logic        o_done,
    input wire logic [31:0] o_rot_x,
    input wire logic [31:0] o_rot_y,
    input wire logic [31:0] o_rot_z,
    input wire logic        o_degenerate
);
    import qrv_pkg::*;

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_degenerate) |->
            (o_rot_x == 32'd0 && o_rot_y == 32'd0 && o_rot_z == 32'd0))
        else $error("degenerate result with nonzero vector");

    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($signed(o_rot_x) <= $signed(ROT_MAX) &&
                    $signed(o_rot_x) >= -$signed(ROT_MAX)))
        else $error("rot_x out of range");

    a_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($signed(o_rot_y) <= $signed(ROT_MAX) &&
                    $signed(o_rot_y) >= -$signed(ROT_MAX)))
        else $error("rot_y out of range");

    a_z_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($signed(o_rot_z) <= $signed(ROT_MAX) &&
                    $signed(o_rot_z) >= -$signed(ROT_MAX)))
        else $error("rot_z out of range");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_done && !busy))
        else $error("strobe or busy right after reset");

endmodule

bind quaternion_to_rotation_vector qrv_checker u_qrv_checker (.*);
`default_nettype wire
